FILE: hdl/ray_triangle_intersect_core_assert.svh
`ifndef RAY_TRIANGLE_INTERSECT_CORE_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_CORE_ASSERT_SVH

// Invariant checked at every clock edge outside reset.
`define RTI_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("rti invariant violated");

// Same-cycle implication.
`define RTI_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rti implication violated");

// Next-cycle implication.
`define RTI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rti next-cycle check violated");

`endif

FILE: hdl/rti_pkg.sv
package rti_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int SPLIT_W = CROSS_W - DIFF_W;
   localparam int LOPP_W  = SPLIT_W + 1 + DIFF_W;
   localparam int TERM_W  = DIFF_W + CROSS_W;
   localparam int NUM_W   = TERM_W + 2;
   localparam int ALPHA_W = NUM_W + 2;
   localparam int REM_W   = ALPHA_W + FRAC_BITS + COORD_WIDTH;
   localparam int QUO_W   = COORD_WIDTH - 1;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z    = 3'd5;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type v0_x;
      coord_type v0_y;
      coord_type v0_z;
      coord_type v1_x;
      coord_type v1_y;
      coord_type v1_z;
      coord_type v2_x;
      coord_type v2_y;
      coord_type v2_z;
   } req_type;

   typedef struct packed {
      logic      hit;
      coord_type bary_alpha;
      coord_type bary_beta;
      coord_type bary_gamma;
      coord_type hit_distance;
   } rsp_type;

   typedef struct packed {
      coord_type org_x;
      coord_type org_y;
      coord_type org_z;
      coord_type dir_x;
      coord_type dir_y;
      coord_type dir_z;
   } ray_type;

   localparam coord_type ONE_FIXED = coord_type'(64'd1 << FRAC_BITS);

   localparam ray_type RAY_RESET = '{
      org_x: '0, org_y: '0, org_z: '0,
      dir_x: '0, dir_y: '0, dir_z: ONE_FIXED
   };

   // exact numerators and determinant of one triangle, plus its classification
   typedef struct packed {
      logic signed [ALPHA_W-1:0] det;
      logic signed [ALPHA_W-1:0] na;
      logic signed [ALPHA_W-1:0] nb;
      logic signed [ALPHA_W-1:0] ng;
      logic signed [ALPHA_W-1:0] nt;
      logic                      front;
      logic                      hit;
   } tri_num_type;

endpackage

FILE: hdl/rti_req_if.sv
interface rti_req_if import rti_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/rti_rsp_if.sv
interface rti_rsp_if import rti_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/rti_front.sv
module rti_front import rti_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ray_type     ray,
   rti_req_if.sink     req_chan,
   output logic        q_valid,
   input  logic        q_ready,
   output tri_num_type q_entry
);

   localparam int NSTG = 7;
   localparam int NDOT = 4;
   localparam int NXT [3] = '{1, 2, 0};
   localparam int PRV [3] = '{2, 0, 1};

   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [CROSS_W-1:0] cross_type;
   typedef logic signed [LOPP_W-1:0]  lopp_type;
   typedef logic signed [TERM_W-1:0]  term_type;
   typedef logic signed [NUM_W-1:0]   num_type;

   logic [NSTG:1] vld_ff, vld_in;
   logic          en;

   coord_type v0 [3];
   coord_type v1 [3];
   coord_type v2 [3];
   coord_type org [3];
   diff_type  dir [3];

   diff_type  e1_ff [1:3][3], e1_in [1:3][3];
   diff_type  e2_ff [1:3][3], e2_in [1:3][3];
   diff_type  s_ff  [1:3][3], s_in  [1:3][3];
   prod_type  qa_ff [3], qa_in [3];
   prod_type  qb_ff [3], qb_in [3];
   prod_type  ra_ff [3], ra_in [3];
   prod_type  rb_ff [3], rb_in [3];
   cross_type q_ff [3], q_in [3];
   cross_type r_ff [3], r_in [3];
   lopp_type  lo_ff [NDOT][3], lo_in [NDOT][3];
   prod_type  hi_ff [NDOT][3], hi_in [NDOT][3];
   term_type  term_ff [NDOT][3], term_in [NDOT][3];
   num_type   sum_ff [NDOT], sum_in [NDOT];
   tri_num_type entry_ff, entry_in;

   assign en             = !vld_ff[NSTG] || q_ready;
   assign req_chan.ready = en;
   assign q_valid        = vld_ff[NSTG];
   assign q_entry        = entry_ff;

   always_comb begin
      v0[0] = req_chan.data.v0_x;
      v0[1] = req_chan.data.v0_y;
      v0[2] = req_chan.data.v0_z;
      v1[0] = req_chan.data.v1_x;
      v1[1] = req_chan.data.v1_y;
      v1[2] = req_chan.data.v1_z;
      v2[0] = req_chan.data.v2_x;
      v2[1] = req_chan.data.v2_y;
      v2[2] = req_chan.data.v2_z;
      org[0] = ray.org_x;
      org[1] = ray.org_y;
      org[2] = ray.org_z;
      dir[0] = DIFF_W'(ray.dir_x);
      dir[1] = DIFF_W'(ray.dir_y);
      dir[2] = DIFF_W'(ray.dir_z);
   end

   always_comb begin
      diff_type  opa;
      cross_type opc;
      logic signed [ALPHA_W-1:0] na;

      vld_in = {vld_ff[NSTG-1:1], req_chan.valid};

      // edges and origin offset
      for (int i = 0; i < 3; i++) begin
         e1_in[1][i] = DIFF_W'(v1[i]) - DIFF_W'(v0[i]);
         e2_in[1][i] = DIFF_W'(v2[i]) - DIFF_W'(v0[i]);
         s_in[1][i]  = DIFF_W'(org[i]) - DIFF_W'(v0[i]);
      end
      for (int k = 2; k <= 3; k++) begin
         e1_in[k] = e1_ff[k-1];
         e2_in[k] = e2_ff[k-1];
         s_in[k]  = s_ff[k-1];
      end

      // cross product terms: q = dir x e2, r = s x e1
      for (int i = 0; i < 3; i++) begin
         qa_in[i] = dir[NXT[i]] * e2_ff[1][PRV[i]];
         qb_in[i] = dir[PRV[i]] * e2_ff[1][NXT[i]];
         ra_in[i] = s_ff[1][NXT[i]] * e1_ff[1][PRV[i]];
         rb_in[i] = s_ff[1][PRV[i]] * e1_ff[1][NXT[i]];
      end

      for (int i = 0; i < 3; i++) begin
         q_in[i] = CROSS_W'(qa_ff[i]) - CROSS_W'(qb_ff[i]);
         r_in[i] = CROSS_W'(ra_ff[i]) - CROSS_W'(rb_ff[i]);
      end

      // dot products split into low and high partial products
      for (int d = 0; d < NDOT; d++) begin
         for (int i = 0; i < 3; i++) begin
            unique case (d)
               0: begin
                  opa = e1_ff[3][i];
                  opc = q_ff[i];
               end
               1: begin
                  opa = s_ff[3][i];
                  opc = q_ff[i];
               end
               2: begin
                  opa = dir[i];
                  opc = r_ff[i];
               end
               default: begin
                  opa = e2_ff[3][i];
                  opc = r_ff[i];
               end
            endcase
            lo_in[d][i] = opa * $signed({1'b0, opc[SPLIT_W-1:0]});
            hi_in[d][i] = opa * $signed(opc[CROSS_W-1:SPLIT_W]);
         end
      end

      for (int d = 0; d < NDOT; d++) begin
         for (int i = 0; i < 3; i++) begin
            term_in[d][i] = (TERM_W'(hi_ff[d][i]) <<< SPLIT_W) + TERM_W'(lo_ff[d][i]);
         end
         sum_in[d] = NUM_W'(term_ff[d][0]) + NUM_W'(term_ff[d][1]) + NUM_W'(term_ff[d][2]);
      end

      na = ALPHA_W'(sum_ff[0]) - ALPHA_W'(sum_ff[1]) - ALPHA_W'(sum_ff[2]);
      entry_in.det   = ALPHA_W'(sum_ff[0]);
      entry_in.na    = na;
      entry_in.nb    = ALPHA_W'(sum_ff[1]);
      entry_in.ng    = ALPHA_W'(sum_ff[2]);
      entry_in.nt    = ALPHA_W'(sum_ff[3]);
      entry_in.front = !sum_ff[0][NUM_W-1] && (sum_ff[0] != '0);
      entry_in.hit   = entry_in.front && !na[ALPHA_W-1] && !sum_ff[1][NUM_W-1]
                       && !sum_ff[2][NUM_W-1] && !sum_ff[3][NUM_W-1]
                       && (sum_ff[3] != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff    <= e1_in;
         e2_ff    <= e2_in;
         s_ff     <= s_in;
         qa_ff    <= qa_in;
         qb_ff    <= qb_in;
         ra_ff    <= ra_in;
         rb_ff    <= rb_in;
         q_ff     <= q_in;
         r_ff     <= r_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         term_ff  <= term_in;
         sum_ff   <= sum_in;
         entry_ff <= entry_in;
      end
   end

endmodule

FILE: hdl/rti_queue.sv
`include "ray_triangle_intersect_core_assert.svh"

module rti_queue import rti_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  tri_num_type push_entry,
   output logic        pop_valid,
   input  logic        pop_ready,
   output tri_num_type pop_entry
);

   tri_num_type       slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              push;
   logic              pop;

   assign push_ready = (cnt_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_entry  = slot_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_in  = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   `RTI_ASSERT_ALWAYS(a_q_cnt_bound, clock, reset, cnt_ff <= QCNT_W'(QDEPTH))
   `RTI_ASSERT_NEXT(a_q_cnt_up, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + QCNT_W'(1))

endmodule

FILE: hdl/rti_back.sv
`include "ray_triangle_intersect_core_assert.svh"

module rti_back import rti_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_ready,
   input  tri_num_type q_entry,
   rti_rsp_if.source   rsp_chan
);

   localparam int LANES = 4;
   localparam logic [COORD_WIDTH-1:0] LIM_POS = {1'b0, {QUO_W{1'b1}}};
   localparam logic [COORD_WIDTH-1:0] LIM_NEG = {1'b1, {QUO_W{1'b0}}};

   typedef logic [REM_W-1:0] rem_type;

   logic [QUO_W:0]       vld_ff, vld_in;
   rem_type              rem_ff [0:QUO_W][LANES], rem_in [0:QUO_W][LANES];
   logic [QUO_W-1:0]     quo_ff [0:QUO_W][LANES], quo_in [0:QUO_W][LANES];
   rem_type              den_ff [0:QUO_W], den_in [0:QUO_W];
   logic [LANES-1:0]     neg_ff [0:QUO_W], neg_in [0:QUO_W];
   logic [LANES-1:0]     sat_ff [0:QUO_W], sat_in [0:QUO_W];
   logic [QUO_W:0]       front_ff, front_in;
   logic [QUO_W:0]       hit_ff, hit_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_vld_ff;
   logic                 en;

   assign en             = !rsp_vld_ff || rsp_chan.ready;
   assign q_ready        = en;
   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.data  = rsp_ff;

   always_comb begin
      logic signed [ALPHA_W-1:0] num [LANES];
      logic [ALPHA_W-1:0]        mag;
      rem_type                   shifted;
      logic [COORD_WIDTH-1:0]    qmag;
      logic [COORD_WIDTH-1:0]    val [LANES];

      num[0] = q_entry.na;
      num[1] = q_entry.nb;
      num[2] = q_entry.ng;
      num[3] = q_entry.nt;

      vld_in      = {vld_ff[QUO_W-1:0], q_valid};
      front_in    = {front_ff[QUO_W-1:0], q_entry.front};
      hit_in      = {hit_ff[QUO_W-1:0], q_entry.hit};
      den_in[0]   = REM_W'($unsigned(q_entry.det));

      // sign, magnitude scaled by the fraction, and overflow check
      for (int l = 0; l < LANES; l++) begin
         neg_in[0][l] = num[l][ALPHA_W-1];
         mag = neg_in[0][l] ? $unsigned(-num[l]) : $unsigned(num[l]);
         rem_in[0][l] = REM_W'(mag) << FRAC_BITS;
         sat_in[0][l] = rem_in[0][l] >= (den_in[0] << QUO_W);
         quo_in[0][l] = '0;
      end

      // restoring division, one quotient bit per stage, MSB first
      for (int k = 1; k <= QUO_W; k++) begin
         den_in[k] = den_ff[k-1];
         neg_in[k] = neg_ff[k-1];
         sat_in[k] = sat_ff[k-1];
         for (int l = 0; l < LANES; l++) begin
            shifted      = den_ff[k-1] << (QUO_W - k);
            rem_in[k][l] = rem_ff[k-1][l];
            quo_in[k][l] = quo_ff[k-1][l];
            if (rem_ff[k-1][l] >= shifted) begin
               rem_in[k][l]              = rem_ff[k-1][l] - shifted;
               quo_in[k][l][QUO_W - k]   = 1'b1;
            end
         end
      end

      for (int l = 0; l < LANES; l++) begin
         if (sat_ff[QUO_W][l]) begin
            qmag = neg_ff[QUO_W][l] ? LIM_NEG : LIM_POS;
         end else begin
            qmag = {1'b0, quo_ff[QUO_W][l]};
         end
         val[l] = neg_ff[QUO_W][l] ? (~qmag + COORD_WIDTH'(1)) : qmag;
      end

      rsp_in.hit          = front_ff[QUO_W] && hit_ff[QUO_W];
      rsp_in.bary_alpha   = front_ff[QUO_W] ? $signed(val[0]) : '0;
      rsp_in.bary_beta    = front_ff[QUO_W] ? $signed(val[1]) : '0;
      rsp_in.bary_gamma   = front_ff[QUO_W] ? $signed(val[2]) : '0;
      rsp_in.hit_distance = front_ff[QUO_W] ? $signed(val[3]) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= vld_in;
         rsp_vld_ff <= vld_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
         den_ff   <= den_in;
         neg_ff   <= neg_in;
         sat_ff   <= sat_in;
         front_ff <= front_in;
         hit_ff   <= hit_in;
         rsp_ff   <= rsp_in;
      end
   end

   `RTI_ASSERT_IMPLIES(a_hit_nonneg, clock, reset, rsp_vld_ff && rsp_ff.hit, !rsp_ff.bary_alpha[COORD_WIDTH-1] && !rsp_ff.bary_beta[COORD_WIDTH-1] && !rsp_ff.bary_gamma[COORD_WIDTH-1] && !rsp_ff.hit_distance[COORD_WIDTH-1])
   `RTI_ASSERT_IMPLIES(a_div_rem, clock, reset, vld_ff[QUO_W] && front_ff[QUO_W] && !sat_ff[QUO_W][0], rem_ff[QUO_W][0] < den_ff[QUO_W])

endmodule

FILE: hdl/ray_triangle_intersect_core.sv
// Throughput: one triangle per cycle while back-pressure does not stall the pipe; seven
// front stages (cross products, then dot products in split multipliers) feed a 4-entry queue,
// then back stages of bit-per-stage restoring division.
// Reset is synchronous, active high: clears pipeline valids and the queue, and sets the
// ray to origin (0,0,0) and direction (0,0,1.0).
module ray_triangle_intersect_core import rti_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   rti_req_if.sink                 req_chan,
   rti_rsp_if.source               rsp_chan,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [COORD_WIDTH-1:0]  csr_wdata
);

   ray_type     ray_ff, ray_in;
   logic        fq_valid;
   logic        fq_ready;
   tri_num_type fq_entry;
   logic        qb_valid;
   logic        qb_ready;
   tri_num_type qb_entry;

   always_comb begin
      ray_in = ray_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X: ray_in.org_x = $signed(csr_wdata);
            CSR_ORIGIN_Y: ray_in.org_y = $signed(csr_wdata);
            CSR_ORIGIN_Z: ray_in.org_z = $signed(csr_wdata);
            CSR_DIR_X:    ray_in.dir_x = $signed(csr_wdata);
            CSR_DIR_Y:    ray_in.dir_y = $signed(csr_wdata);
            CSR_DIR_Z:    ray_in.dir_z = $signed(csr_wdata);
            default:      ray_in = ray_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ray_ff <= RAY_RESET;
      end else begin
         ray_ff <= ray_in;
      end
   end

   rti_front u_front (
      .clock    (clock),
      .reset    (reset),
      .ray      (ray_ff),
      .req_chan (req_chan),
      .q_valid  (fq_valid),
      .q_ready  (fq_ready),
      .q_entry  (fq_entry)
   );

   rti_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_entry (fq_entry),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_entry  (qb_entry)
   );

   rti_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (qb_valid),
      .q_ready  (qb_ready),
      .q_entry  (qb_entry),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: tb/sv/rti_checker.sv
module rti_checker import rti_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   rti_req_if                     req_chan,
   rti_rsp_if                     rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [COORD_WIDTH-1:0] csr_wdata,
   output int                     errors,
   output int                     pending
);

   typedef logic signed [159:0] big_type;

   ray_type ray_regs;
   rsp_type expected_hits[$];

   // n * 2^FRAC_BITS / den, truncated toward zero and clamped; den > 0
   function automatic coord_type fixed_quot(big_type n, big_type den);
      logic    neg;
      big_type mag;
      big_type lim;
      neg = n < 0;
      mag = neg ? -n : n;
      mag = (mag <<< FRAC_BITS) / den;
      lim = big_type'(1) <<< (COORD_WIDTH - 1);
      if (!neg) lim = lim - 1;
      if (mag > lim) mag = lim;
      return neg ? coord_type'(-mag) : coord_type'(mag);
   endfunction

   function automatic rsp_type predict_hit(req_type t, ray_type r);
      big_type e1x, e1y, e1z, e2x, e2y, e2z, sx, sy, sz;
      big_type dx, dy, dz, qx, qy, qz, rx, ry, rz;
      big_type det, nb, ng, na, nt;
      rsp_type res;
      e1x = big_type'(t.v1_x) - big_type'(t.v0_x);
      e1y = big_type'(t.v1_y) - big_type'(t.v0_y);
      e1z = big_type'(t.v1_z) - big_type'(t.v0_z);
      e2x = big_type'(t.v2_x) - big_type'(t.v0_x);
      e2y = big_type'(t.v2_y) - big_type'(t.v0_y);
      e2z = big_type'(t.v2_z) - big_type'(t.v0_z);
      sx  = big_type'(r.org_x) - big_type'(t.v0_x);
      sy  = big_type'(r.org_y) - big_type'(t.v0_y);
      sz  = big_type'(r.org_z) - big_type'(t.v0_z);
      dx  = big_type'(r.dir_x);
      dy  = big_type'(r.dir_y);
      dz  = big_type'(r.dir_z);
      qx  = dy * e2z - dz * e2y;
      qy  = dz * e2x - dx * e2z;
      qz  = dx * e2y - dy * e2x;
      rx  = sy * e1z - sz * e1y;
      ry  = sz * e1x - sx * e1z;
      rz  = sx * e1y - sy * e1x;
      det = e1x * qx + e1y * qy + e1z * qz;
      res = '0;
      if (det <= 0) return res;
      nb = sx * qx + sy * qy + sz * qz;
      ng = dx * rx + dy * ry + dz * rz;
      nt = e2x * rx + e2y * ry + e2z * rz;
      na = det - nb - ng;
      res.hit          = (na >= 0) && (nb >= 0) && (ng >= 0) && (nt > 0);
      res.bary_alpha   = fixed_quot(na, det);
      res.bary_beta    = fixed_quot(nb, det);
      res.bary_gamma   = fixed_quot(ng, det);
      res.hit_distance = fixed_quot(nt, det);
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_r;
      rsp_type act_r;
      if (reset) begin
         ray_regs = RAY_RESET;
         errors   = 0;
         expected_hits.delete();
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_hits.push_back(predict_hit(req_chan.data, ray_regs));
         if (rsp_chan.valid && rsp_chan.ready) begin
            act_r = rsp_chan.data;
            if (expected_hits.size() == 0) begin
               $display("%0t: unexpected response %h", $time, act_r);
               errors = errors + 1;
            end else begin
               exp_r = expected_hits.pop_front();
               if (exp_r.hit !== act_r.hit) begin
                  $display("%0t: hit exp %0b act %0b", $time, exp_r.hit, act_r.hit);
                  errors = errors + 1;
               end
               if (exp_r.bary_alpha !== act_r.bary_alpha) begin
                  $display("%0t: alpha exp %h act %h", $time, exp_r.bary_alpha,
                           act_r.bary_alpha);
                  errors = errors + 1;
               end
               if (exp_r.bary_beta !== act_r.bary_beta) begin
                  $display("%0t: beta exp %h act %h", $time, exp_r.bary_beta,
                           act_r.bary_beta);
                  errors = errors + 1;
               end
               if (exp_r.bary_gamma !== act_r.bary_gamma) begin
                  $display("%0t: gamma exp %h act %h", $time, exp_r.bary_gamma,
                           act_r.bary_gamma);
                  errors = errors + 1;
               end
               if (exp_r.hit_distance !== act_r.hit_distance) begin
                  $display("%0t: distance exp %h act %h", $time, exp_r.hit_distance,
                           act_r.hit_distance);
                  errors = errors + 1;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ORIGIN_X: ray_regs.org_x = csr_wdata;
               CSR_ORIGIN_Y: ray_regs.org_y = csr_wdata;
               CSR_ORIGIN_Z: ray_regs.org_z = csr_wdata;
               CSR_DIR_X:    ray_regs.dir_x = csr_wdata;
               CSR_DIR_Y:    ray_regs.dir_y = csr_wdata;
               CSR_DIR_Z:    ray_regs.dir_z = csr_wdata;
               default: ;
            endcase
         end
      end
      pending = expected_hits.size();
   end

endmodule

FILE: tb/sv/testbench.sv
module testbench;
   import rti_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam coord_type CMAX = 32'sh7fffffff;
   localparam coord_type CMIN = 32'sh80000000;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [COORD_WIDTH-1:0] csr_wdata;
   int                     errors;
   int                     pending;
   int                     send_idle;
   int                     rcv_idle;
   int                     stall_count;
   ray_type                ray_now;

   rti_req_if req_chan ();
   rti_rsp_if rsp_chan ();

   ray_triangle_intersect_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rti_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .errors    (errors),
      .pending   (pending)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(99) >= rcv_idle);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_count = 0;
      else
         stall_count = stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, coord_type val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_ORIGIN_X: ray_now.org_x = val;
         CSR_ORIGIN_Y: ray_now.org_y = val;
         CSR_ORIGIN_Z: ray_now.org_z = val;
         CSR_DIR_X:    ray_now.dir_x = val;
         CSR_DIR_Y:    ray_now.dir_y = val;
         CSR_DIR_Z:    ray_now.dir_z = val;
         default: ;
      endcase
   endtask

   task automatic set_ray(coord_type ox, coord_type oy, coord_type oz,
                          coord_type dx, coord_type dy, coord_type dz);
      drain();
      csr_write(CSR_ORIGIN_X, ox);
      csr_write(CSR_ORIGIN_Y, oy);
      csr_write(CSR_ORIGIN_Z, oz);
      csr_write(CSR_DIR_X, dx);
      csr_write(CSR_DIR_Y, dy);
      csr_write(CSR_DIR_Z, dz);
      csr_write(3'd6, $urandom);
      csr_write(3'd7, $urandom);
   endtask

   task automatic send_tri(req_type t);
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= t;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   function automatic req_type make_tri(coord_type ax, coord_type ay, coord_type az,
                                        coord_type bx, coord_type by, coord_type bz,
                                        coord_type cx, coord_type cy, coord_type cz);
      req_type t;
      t = '{ax, ay, az, bx, by, bz, cx, cy, cz};
      return t;
   endfunction

   function automatic coord_type small_off();
      return coord_type'($signed($urandom_range(524288)) - 262144);
   endfunction

   // triangle built around a point on the current ray, random winding
   function automatic req_type ray_tri();
      longint  tt;
      longint  px, py, pz;
      req_type t;
      tt = longint'($urandom_range(20 << 16)) - longint'(2 << 16);
      px = longint'(ray_now.org_x) + ((longint'(ray_now.dir_x) * tt) >>> 16);
      py = longint'(ray_now.org_y) + ((longint'(ray_now.dir_y) * tt) >>> 16);
      pz = longint'(ray_now.org_z) + ((longint'(ray_now.dir_z) * tt) >>> 16);
      t.v0_x = coord_type'(px) + small_off();
      t.v0_y = coord_type'(py) + small_off();
      t.v0_z = coord_type'(pz) + small_off();
      t.v1_x = coord_type'(px) + small_off();
      t.v1_y = coord_type'(py) + small_off();
      t.v1_z = coord_type'(pz) + small_off();
      t.v2_x = coord_type'(px) + small_off();
      t.v2_y = coord_type'(py) + small_off();
      t.v2_z = coord_type'(pz) + small_off();
      if ($urandom_range(9) == 0) begin
         t.v2_x = t.v1_x;
         t.v2_y = t.v1_y;
         t.v2_z = t.v1_z;
      end
      return t;
   endfunction

   function automatic req_type wild_tri();
      req_type t;
      t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
      return t;
   endfunction

   task automatic random_items(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 80) send_tri(ray_tri());
         else send_tri(wild_tri());
      end
      req_chan.valid <= 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      send_idle      = 12;
      rcv_idle       = 65;
      ray_now        = RAY_RESET;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // reset ray: origin 0, direction +z
      send_tri(make_tri(0, 0, 32'sh50000, 32'sh0, 32'sh10000, 32'sh50000,
                        32'sh10000, 32'sh0, 32'sh50000));
      send_tri(make_tri(-32'sh10000, -32'sh10000, 32'sh50000, -32'sh10000, 32'sh10000,
                        32'sh50000, 32'sh10000, -32'sh10000, 32'sh50000));
      send_tri(make_tri(0, 0, 32'sh50000, 32'sh10000, 0, 32'sh50000,
                        0, 32'sh10000, 32'sh50000));
      send_tri(make_tri(-32'sh10000, -32'sh10000, -32'sh50000, -32'sh10000, 32'sh10000,
                        -32'sh50000, 32'sh10000, -32'sh10000, -32'sh50000));
      send_tri(make_tri(-32'sh10000, -32'sh10000, 0, -32'sh10000, 32'sh10000,
                        0, 32'sh10000, -32'sh10000, 0));
      send_tri(make_tri(0, 0, 32'sh50000, 0, 32'sh10000, 32'sh50000,
                        32'sh10000, 0, 32'sh50000));
      send_tri(make_tri(32'sh8000, 0, 32'sh50000, 32'sh8000, 32'sh10000, 32'sh50000,
                        32'sh18000, 0, 32'sh50000));
      send_tri(make_tri(0, 0, 32'sh50000, 32'sh10000, 32'sh10000, 32'sh50000,
                        32'sh20000, 32'sh20000, 32'sh50000));
      send_tri(make_tri(CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX));
      send_tri(make_tri(CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN));
      send_tri(make_tri(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN));
      send_tri(make_tri(0, 0, 1, 0, 1, 1, 1, 0, 1));
      send_tri(make_tri(0, 0, CMAX, 0, 1, CMAX, 1, 0, CMAX));
      send_tri('0);
      req_chan.valid <= 1'b0;

      set_ray(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX);
      send_tri(make_tri(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN));
      send_tri(make_tri(0, 0, 0, CMAX, 0, 0, 0, CMAX, CMAX));
      send_tri(wild_tri());
      req_chan.valid <= 1'b0;
      set_ray(0, 0, 0, 0, 0, 0);
      send_tri(make_tri(0, 0, 32'sh50000, 32'sh0, 32'sh10000, 32'sh50000,
                        32'sh10000, 0, 32'sh50000));
      req_chan.valid <= 1'b0;

      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin
            send_idle = 65;
            rcv_idle  = 12;
         end
         if (phase == 4) begin
            send_idle = 0;
            rcv_idle  = 0;
         end
         case (phase)
            0: set_ray(0, 0, 0, 0, 0, 32'sh10000);
            1: set_ray(32'sh30000, -32'sh20000, -32'sh100000, 0, 32'sh8000, 32'shddb3);
            2: set_ray(CMAX, CMIN, 0, -32'sh10000, 0, 0);
            3: set_ray(small_off(), small_off(), small_off(),
                       32'shb505, -32'shb505, 0);
            4: set_ray(-32'sh50000, 32'sh50000, 32'sh10000, 32'sh93cd, 32'sh93cd, 32'sh93cd);
            default: set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         endcase
         random_items(115);
      end

      drain();
      if (errors == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
